@@ hw/rtl/segment_densify_by_length_or_count_defines.svh @@
// Assertion macros for the checker file.
// Each macro expects the clock i_clk and the reset i_rst_n in scope.
`ifndef SEGMENT_DENSIFY_BY_LENGTH_OR_COUNT_DEFINES_SVH
`define SEGMENT_DENSIFY_BY_LENGTH_OR_COUNT_DEFINES_SVH

// Same-cycle implication.
`define SDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sdl_pkg.sv @@
// ----------------------------------------------------------------------------
// sdl_pkg
// Types, widths and codes shared by the segment densifier modules.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int RAD_BITS   = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = DIFF_BITS;
    localparam int REM_BITS   = ROOT_BITS + 3;
    localparam int LEN_BITS   = 24;
    localparam int DVD_BITS   = DIFF_BITS + 1;
    localparam int DVR_BITS   = LEN_BITS + 1;
    localparam int ACC_BITS   = DVD_BITS + 1;
    localparam int K_BITS     = 6;
    localparam int DEN_BITS   = K_BITS + 1;
    localparam int IDX_BITS   = 7;
    localparam int CNT_BITS   = 5;
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int DIV_STEPS  = DVD_BITS;
    localparam int CFG_BITS   = LEN_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        logic   final_segment;
    } t_in;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   run_end;
        logic   count_clipped;
    } t_out;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODE_SELECT = 2'd0;
    localparam t_cfg_idx CFG_MAX_LENGTH  = 2'd1;
    localparam t_cfg_idx CFG_FIXED_COUNT = 2'd2;
    localparam t_cfg_idx CFG_CLOSED_RING = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_SQRT,
        S_DIVK_LOAD,
        S_DIVK,
        S_KSET,
        S_DIVD_LOAD,
        S_DIVD,
        S_DSET,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_SUM,
        OP_SQRT_STEP,
        OP_DIVK_LOAD,
        OP_DIV_STEP,
        OP_KSET,
        OP_DIVD_LOAD,
        OP_DSET,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mode_len;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

@@ hw/rtl/sdl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdl_ctrl
// Sequencer: square, root and divides as the mode needs, then emission.
// ----------------------------------------------------------------------------
module sdl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sdl_pkg::t_status i_status,
    output sdl_pkg::t_cmd    o_cmd
);

    localparam logic [sdl_pkg::CNT_BITS-1:0] SQRT_LAST =
        sdl_pkg::CNT_BITS'(sdl_pkg::SQRT_STEPS - 1);
    localparam logic [sdl_pkg::CNT_BITS-1:0] DIV_LAST =
        sdl_pkg::CNT_BITS'(sdl_pkg::DIV_STEPS - 1);

    sdl_pkg::t_state r_state, n_state;
    logic [sdl_pkg::CNT_BITS-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdl_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            sdl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.mode_len ? sdl_pkg::S_SQUARE : sdl_pkg::S_KSET;
                end
            end
            sdl_pkg::S_SQUARE:    n_state = sdl_pkg::S_SUM;
            sdl_pkg::S_SUM:       n_state = sdl_pkg::S_SQRT;
            sdl_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = sdl_pkg::S_DIVK_LOAD;
                    n_cnt   = '0;
                end
            end
            sdl_pkg::S_DIVK_LOAD: n_state = sdl_pkg::S_DIVK;
            sdl_pkg::S_DIVK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = sdl_pkg::S_KSET;
                    n_cnt   = '0;
                end
            end
            sdl_pkg::S_KSET:      n_state = sdl_pkg::S_DIVD_LOAD;
            sdl_pkg::S_DIVD_LOAD: n_state = sdl_pkg::S_DIVD;
            sdl_pkg::S_DIVD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = sdl_pkg::S_DSET;
                    n_cnt   = '0;
                end
            end
            sdl_pkg::S_DSET:      n_state = sdl_pkg::S_EMIT;
            sdl_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = sdl_pkg::S_IDLE;
                end
            end
            default:              n_state = sdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = sdl_pkg::OP_NONE;
        case (r_state)
            sdl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = sdl_pkg::OP_LOAD;
                end
            end
            sdl_pkg::S_SQUARE:    o_cmd.op = sdl_pkg::OP_SQUARE;
            sdl_pkg::S_SUM:       o_cmd.op = sdl_pkg::OP_SUM;
            sdl_pkg::S_SQRT:      o_cmd.op = sdl_pkg::OP_SQRT_STEP;
            sdl_pkg::S_DIVK_LOAD: o_cmd.op = sdl_pkg::OP_DIVK_LOAD;
            sdl_pkg::S_DIVK:      o_cmd.op = sdl_pkg::OP_DIV_STEP;
            sdl_pkg::S_KSET:      o_cmd.op = sdl_pkg::OP_KSET;
            sdl_pkg::S_DIVD_LOAD: o_cmd.op = sdl_pkg::OP_DIVD_LOAD;
            sdl_pkg::S_DIVD:      o_cmd.op = sdl_pkg::OP_DIV_STEP;
            sdl_pkg::S_DSET:      o_cmd.op = sdl_pkg::OP_DSET;
            sdl_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = sdl_pkg::OP_EMIT;
                end
            end
            default:              o_cmd.op = sdl_pkg::OP_NONE;
        endcase
    end

endmodule

@@ hw/rtl/sdl_datapath.sv @@
// ----------------------------------------------------------------------------
// sdl_datapath
// Config registers, squarer, bitwise root, two divider lanes, point stepper.
// ----------------------------------------------------------------------------
module sdl_datapath #(
    parameter int MAX_INSERTS = 62
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdl_pkg::t_cmd                 i_cmd,
    output sdl_pkg::t_status              o_status,
    input  sdl_pkg::t_in                  i_in_data,
    input  logic                          i_cfg_we,
    input  sdl_pkg::t_cfg_idx             i_cfg_index,
    input  logic [sdl_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sdl_pkg::t_out                 o_out_data
);

    localparam int CB  = sdl_pkg::COORD_BITS;
    localparam int DB  = sdl_pkg::DIFF_BITS;
    localparam int RB  = sdl_pkg::RAD_BITS;
    localparam int OB  = sdl_pkg::ROOT_BITS;
    localparam int MB  = sdl_pkg::REM_BITS;
    localparam int LB  = sdl_pkg::LEN_BITS;
    localparam int VB  = sdl_pkg::DVD_BITS;
    localparam int WB  = sdl_pkg::DVR_BITS;
    localparam int AB  = sdl_pkg::ACC_BITS;
    localparam int KB  = sdl_pkg::K_BITS;
    localparam int NB  = sdl_pkg::DEN_BITS;
    localparam int IB  = sdl_pkg::IDX_BITS;

    // configuration
    logic          r_mode;
    logic [LB-1:0] r_max_len;
    logic [KB-1:0] r_fixed;
    logic          r_ring;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_max_len <= LB'(4096);
            r_fixed   <= KB'(1);
            r_ring    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdl_pkg::CFG_MODE_SELECT: r_mode    <= i_cfg_data[0];
                sdl_pkg::CFG_MAX_LENGTH:  r_max_len <= i_cfg_data[LB-1:0];
                sdl_pkg::CFG_FIXED_COUNT: r_fixed   <= i_cfg_data[KB-1:0];
                sdl_pkg::CFG_CLOSED_RING: r_ring    <= i_cfg_data[0];
                default:                  r_ring    <= r_ring;
            endcase
        end
    end

    // segment payload
    sdl_pkg::t_coord r_sx, r_sy, r_ex, r_ey;
    logic            r_last;
    logic signed [DB-1:0] r_dx, r_dy;
    logic [RB-1:0] r_sqx, r_sqy, r_rad;
    logic [OB-1:0] r_root;
    logic [MB-1:0] r_srem;
    logic [VB-1:0] r_dvd_a, r_dvd_b;
    logic [WB-1:0] r_drem_a, r_drem_b;
    logic [LB-1:0] r_dvs;
    logic [KB-1:0] r_k;
    logic          r_clip;
    logic [NB-1:0] r_den;
    logic signed [AB-1:0] r_stepx, r_stepy, r_accx, r_accy;
    logic [NB-1:0] r_fracx, r_fracy, r_resx, r_resy;
    logic [IB-1:0] r_idx, r_total;
    logic          r_out_valid;
    sdl_pkg::t_out r_out;

    logic [DB-1:0] ax, ay;
    logic [RB-1:0] sq_x, sq_y;
    assign ax   = r_dx[DB-1] ? DB'(-r_dx) : DB'(r_dx);
    assign ay   = r_dy[DB-1] ? DB'(-r_dy) : DB'(r_dy);
    assign sq_x = RB'(ax) * RB'(ax);
    assign sq_y = RB'(ay) * RB'(ay);

    // root step: two radicand bits per cycle
    logic [MB-1:0] s_tmp, s_trial;
    logic          s_ge;
    assign s_tmp   = {r_srem[MB-3:0], r_rad[RB-1 -: 2]};
    assign s_trial = MB'({r_root, 2'b01});
    assign s_ge    = (s_tmp >= s_trial);

    // restoring divide step, both lanes share the divisor
    logic [WB-1:0] a_tmp, b_tmp, dvs_ext;
    logic          a_ge, b_ge;
    assign dvs_ext = {1'b0, r_dvs};
    assign a_tmp   = {r_drem_a[WB-2:0], r_dvd_a[VB-1]};
    assign b_tmp   = {r_drem_b[WB-2:0], r_dvd_b[VB-1]};
    assign a_ge    = (a_tmp >= dvs_ext);
    assign b_ge    = (b_tmp >= dvs_ext);

    // insert count
    logic [VB-1:0] k_raw;
    logic          k_clip;
    logic [KB-1:0] k_val;
    logic          emit_end;
    assign k_raw    = r_mode ? VB'(r_fixed) : r_dvd_a;
    assign k_clip   = (k_raw > VB'(MAX_INSERTS));
    assign k_val    = k_clip ? KB'(MAX_INSERTS) : k_raw[KB-1:0];
    assign emit_end = r_last && !r_ring;

    // floor-signed step and fraction per axis
    logic signed [AB-1:0] qsx, qsy, stx, sty;
    logic [NB-1:0] rax, ray, frx, fry;
    assign qsx = $signed({1'b0, r_dvd_a});
    assign qsy = $signed({1'b0, r_dvd_b});
    assign rax = r_drem_a[NB-1:0];
    assign ray = r_drem_b[NB-1:0];
    always_comb begin
        stx = qsx;
        frx = rax;
        if (r_dx[DB-1]) begin
            if (rax != '0) begin
                stx = ~qsx;
                frx = r_den - rax;
            end else begin
                stx = -qsx;
                frx = '0;
            end
        end
        sty = qsy;
        fry = ray;
        if (r_dy[DB-1]) begin
            if (ray != '0) begin
                sty = ~qsy;
                fry = r_den - ray;
            end else begin
                sty = -qsy;
                fry = '0;
            end
        end
    end

    // point generation
    logic [NB:0] sum_rx, sum_ry;
    logic        wrap_x, wrap_y;
    logic signed [AB-1:0] px_full, py_full;
    sdl_pkg::t_out pt;
    assign sum_rx  = {1'b0, r_resx} + {1'b0, r_fracx};
    assign sum_ry  = {1'b0, r_resy} + {1'b0, r_fracy};
    assign wrap_x  = (sum_rx >= {1'b0, r_den});
    assign wrap_y  = (sum_ry >= {1'b0, r_den});
    assign px_full = AB'(r_sx) + r_accx;
    assign py_full = AB'(r_sy) + r_accy;
    always_comb begin
        if (r_idx == '0) begin
            pt.point_x = r_sx;
            pt.point_y = r_sy;
        end else if (r_idx <= IB'(r_k)) begin
            pt.point_x = px_full[CB-1:0];
            pt.point_y = py_full[CB-1:0];
        end else begin
            pt.point_x = r_ex;
            pt.point_y = r_ey;
        end
        pt.run_end       = (r_idx == r_total);
        pt.count_clipped = r_clip;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sdl_pkg::OP_LOAD: begin
                r_sx   <= i_in_data.start_x;
                r_sy   <= i_in_data.start_y;
                r_ex   <= i_in_data.end_x;
                r_ey   <= i_in_data.end_y;
                r_last <= i_in_data.final_segment;
                r_dx   <= DB'(i_in_data.end_x) - DB'(i_in_data.start_x);
                r_dy   <= DB'(i_in_data.end_y) - DB'(i_in_data.start_y);
            end
            sdl_pkg::OP_SQUARE: begin
                r_sqx <= sq_x;
                r_sqy <= sq_y;
            end
            sdl_pkg::OP_SUM: begin
                r_rad  <= r_sqx + r_sqy;
                r_root <= '0;
                r_srem <= '0;
            end
            sdl_pkg::OP_SQRT_STEP: begin
                r_rad  <= {r_rad[RB-3:0], 2'b00};
                r_srem <= s_ge ? (s_tmp - s_trial) : s_tmp;
                r_root <= {r_root[OB-2:0], s_ge};
            end
            sdl_pkg::OP_DIVK_LOAD: begin
                r_dvd_a  <= VB'(r_root);
                r_dvd_b  <= '0;
                r_drem_a <= '0;
                r_drem_b <= '0;
                r_dvs    <= (r_max_len == '0) ? LB'(1) : r_max_len;
            end
            sdl_pkg::OP_DIV_STEP: begin
                r_drem_a <= a_ge ? (a_tmp - dvs_ext) : a_tmp;
                r_drem_b <= b_ge ? (b_tmp - dvs_ext) : b_tmp;
                r_dvd_a  <= {r_dvd_a[VB-2:0], a_ge};
                r_dvd_b  <= {r_dvd_b[VB-2:0], b_ge};
            end
            sdl_pkg::OP_KSET: begin
                r_k     <= k_val;
                r_clip  <= k_clip;
                r_den   <= {KB'(k_val + 1'b1), 1'b0};
                r_total <= IB'(k_val) + IB'(emit_end);
            end
            sdl_pkg::OP_DIVD_LOAD: begin
                r_dvd_a  <= {ax, 1'b0};
                r_dvd_b  <= {ay, 1'b0};
                r_drem_a <= '0;
                r_drem_b <= '0;
                r_dvs    <= LB'(r_den);
            end
            sdl_pkg::OP_DSET: begin
                r_stepx <= stx;
                r_stepy <= sty;
                r_fracx <= frx;
                r_fracy <= fry;
                r_accx  <= '0;
                r_accy  <= '0;
                r_resx  <= NB'(r_den[NB-1:1]);
                r_resy  <= NB'(r_den[NB-1:1]);
                r_idx   <= '0;
            end
            sdl_pkg::OP_EMIT: begin
                r_out  <= pt;
                r_idx  <= r_idx + 1'b1;
                // advance to the next insert: add step, carry the fraction
                r_accx <= r_accx + r_stepx + AB'(wrap_x);
                r_accy <= r_accy + r_stepy + AB'(wrap_y);
                r_resx <= wrap_x ? NB'(sum_rx - {1'b0, r_den}) : NB'(sum_rx);
                r_resy <= wrap_y ? NB'(sum_ry - {1'b0, r_den}) : NB'(sum_ry);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == sdl_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.mode_len  = !r_mode;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = (r_idx == r_total);

endmodule

@@ hw/rtl/segment_densify_by_length_or_count.sv @@
// ----------------------------------------------------------------------------
// segment_densify_by_length_or_count
// Splits each input segment into evenly spaced vertices.
// ----------------------------------------------------------------------------
// One segment is taken at a time. In length mode a segment is squared and
// summed, then takes 25 root steps, 26 steps to divide by max_length, 26 steps
// for the two per-axis step divides and the load and set states between them,
// then emits one vertex per cycle while the output register is free (1 + k,
// plus the end point on the last segment of an open line). Count mode skips the
// square, root and first divide. The bit-serial root and divider lanes set the
// set-up time; the output register sets the emission rate. A new segment is
// taken once the last vertex of the previous one is in the output register.
module segment_densify_by_length_or_count #(
    parameter int MAX_INSERTS = 62
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sdl_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sdl_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  sdl_pkg::t_cfg_idx             i_cfg_index,
    input  logic [sdl_pkg::CFG_BITS-1:0]  i_cfg_data
);

    sdl_pkg::t_cmd    cmd;
    sdl_pkg::t_status status;

    sdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdl_datapath #(
        .MAX_INSERTS (MAX_INSERTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/sdl_checker.sv @@
// ----------------------------------------------------------------------------
// sdl_checker
// Port-level checks on the segment densifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_densify_by_length_or_count_defines.svh"

module sdl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input sdl_pkg::t_out                 o_out_data
);

    logic in_xfer, out_xfer;
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    `SDL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")
    `SDL_ASSERT_NEXT(a_busy_after_take, in_xfer, !o_in_ready, "ready stayed high after a segment transfer")
    `SDL_ASSERT_NEXT(a_run_continues, out_xfer && !o_out_data.run_end, o_out_valid, "gap inside a vertex run")
    `SDL_ASSERT_NOW(a_idle_only_tail, o_in_ready && o_out_valid, o_out_data.run_end, "idle with a run unfinished")

endmodule

bind segment_densify_by_length_or_count sdl_checker u_sdl_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment densifier: directed segments from a
// stimulus table, then random segments under changing register settings,
// all checked point by point against a behavioural prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD   = 4;
    localparam int IDLE_LIMIT    = 6000;
    localparam int SETTLE_CYCLES = 120;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 48;
    localparam int HOLD_CYCLES   = 700;
    localparam int MAX_K         = 62;
    localparam int CMIN          = -8388608;
    localparam int CMAX          = 8388607;

    typedef struct {
        bit           set_regs;
        bit           mode;
        int unsigned  max_len;
        int unsigned  count;
        bit           ring;
        sdl_pkg::t_in seg;
        int           n_points;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    sdl_pkg::t_in                 i_in_data = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    sdl_pkg::t_out                o_out_data;
    logic                         i_cfg_we = 1'b0;
    sdl_pkg::t_cfg_idx            i_cfg_index = sdl_pkg::CFG_MODE_SELECT;
    logic [sdl_pkg::CFG_BITS-1:0] i_cfg_data = '0;

    // register shadow used by the point prediction
    bit          mode_count;
    int unsigned piece_len;
    int unsigned insert_count;
    bit          ring_mode;

    sdl_pkg::t_out expected_pts[$];
    int   errors = 0;
    int   burst_left = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   ready_style = 0;
    int   style_left = 0;
    int   idle_cycles = 0;

    segment_densify_by_length_or_count u_top (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned cand;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    // nearest, ties toward +infinity
    function automatic longint step_offset(longint d, longint i, longint n);
        longint num = 2 * i * d + n;
        longint den = 2 * n;
        longint q = num / den;
        if (num < 0 && (num % den) != 0) q--;
        return q;
    endfunction

    function automatic int densify(sdl_pkg::t_in seg);
        longint sx = seg.start_x;
        longint sy = seg.start_y;
        longint ex = seg.end_x;
        longint ey = seg.end_y;
        longint dx = ex - sx;
        longint dy = ey - sy;
        longint unsigned ax, ay, len, ml, k;
        bit clipped = 1'b0;
        bit with_end = seg.final_segment && !ring_mode;
        int total;
        sdl_pkg::t_out pt;
        if (!mode_count) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            len = floor_root(ax * ax + ay * ay);
            ml = piece_len == 0 ? 1 : piece_len;
            k = len / ml;
        end else begin
            k = insert_count;
        end
        if (k > MAX_K) begin
            k = MAX_K;
            clipped = 1'b1;
        end
        total = 1 + int'(k) + (with_end ? 1 : 0);
        for (int r = 0; r < total; r++) begin
            if (r == 0) begin
                pt.point_x = sdl_pkg::t_coord'(sx);
                pt.point_y = sdl_pkg::t_coord'(sy);
            end else if (r <= int'(k)) begin
                pt.point_x = sdl_pkg::t_coord'(sx + step_offset(dx, r, longint'(k) + 1));
                pt.point_y = sdl_pkg::t_coord'(sy + step_offset(dy, r, longint'(k) + 1));
            end else begin
                pt.point_x = sdl_pkg::t_coord'(ex);
                pt.point_y = sdl_pkg::t_coord'(ey);
            end
            pt.run_end = (r == total - 1);
            pt.count_clipped = clipped;
            expected_pts = {expected_pts, pt};
        end
        return total;
    endfunction

    task automatic write_reg(sdl_pkg::t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[sdl_pkg::CFG_BITS-1:0];
    endtask

    task automatic set_regs(bit mode, int unsigned ml, int unsigned cnt, bit ring);
        write_reg(sdl_pkg::CFG_MODE_SELECT, mode);
        write_reg(sdl_pkg::CFG_MAX_LENGTH, ml);
        write_reg(sdl_pkg::CFG_FIXED_COUNT, cnt);
        write_reg(sdl_pkg::CFG_CLOSED_RING, ring);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_count   = mode;
        piece_len    = ml & 24'hFFFFFF;
        insert_count = cnt & 6'h3F;
        ring_mode    = ring;
    endtask

    task automatic drain();
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bursts of transfers with random gaps; valid stays high inside a burst
    task automatic send(sdl_pkg::t_in seg, int n_points, bit no_gaps);
        int got;
        if (burst_left == 0 && !no_gaps) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= seg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = densify(seg);
        if (n_points >= 0 && got != n_points)
            report($sformatf("segment gives %0d points, table says %0d", got, n_points));
        if (burst_left > 0) burst_left--;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic t_row row(bit wr, bit mode, int unsigned ml, int unsigned cnt,
                                 bit ring, int sx, int sy, int ex, int ey, bit fin,
                                 int n);
        t_row r;
        r.set_regs = wr;
        r.mode = mode;
        r.max_len = ml;
        r.count = cnt;
        r.ring = ring;
        r.seg.start_x = sdl_pkg::t_coord'(sx);
        r.seg.start_y = sdl_pkg::t_coord'(sy);
        r.seg.end_x = sdl_pkg::t_coord'(ex);
        r.seg.end_y = sdl_pkg::t_coord'(ey);
        r.seg.final_segment = fin;
        r.n_points = n;
        return r;
    endfunction

    function automatic int clamp(longint v);
        if (v < CMIN) return CMIN;
        if (v > CMAX) return CMAX;
        return int'(v);
    endfunction

    function automatic sdl_pkg::t_in random_seg();
        sdl_pkg::t_in s;
        int sx, sy;
        if ($urandom_range(0, 7) == 0) begin
            s = sdl_pkg::t_in'({$urandom, $urandom, $urandom});
        end else begin
            sx = $signed($urandom) >>> $urandom_range(8, 24);
            sy = $signed($urandom) >>> $urandom_range(8, 24);
            s.start_x = sdl_pkg::t_coord'(sx);
            s.start_y = sdl_pkg::t_coord'(sy);
            s.end_x = sdl_pkg::t_coord'(clamp(longint'(sx) +
                                     ($signed($urandom) >>> $urandom_range(8, 31))));
            s.end_y = sdl_pkg::t_coord'(clamp(longint'(sy) +
                                     ($signed($urandom) >>> $urandom_range(8, 31))));
            s.final_segment = ($urandom_range(0, 3) == 0);
        end
        return s;
    endfunction

    // receiver: stall pattern of its own, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(50, 300);
        end else begin
            style_left--;
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (ready_style)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        sdl_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pts.size() == 0) begin
                report("point with none expected");
            end else begin
                want = expected_pts.pop_front();
                if (o_out_data.point_x !== want.point_x)
                    report($sformatf("point_x %0d, want %0d",
                                     o_out_data.point_x, want.point_x));
                if (o_out_data.point_y !== want.point_y)
                    report($sformatf("point_y %0d, want %0d",
                                     o_out_data.point_y, want.point_y));
                if (o_out_data.run_end !== want.run_end)
                    report($sformatf("run_end %b, want %b",
                                     o_out_data.run_end, want.run_end));
                if (o_out_data.count_clipped !== want.count_clipped)
                    report($sformatf("count_clipped %b, want %b",
                                     o_out_data.count_clipped, want.count_clipped));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int unsigned ml;

        mode_count   = 1'b0;
        piece_len    = 4096;
        insert_count = 1;
        ring_mode    = 1'b0;

        rows = {rows, row(1, 0, 4096, 1, 0, 0, 0, 0, 0, 0, 1)};
        rows = {rows, row(0, 0, 4096, 1, 0, 0, 0, 12288, 16384, 0, 6)};
        rows = {rows, row(0, 0, 4096, 1, 0, CMIN, CMIN, CMAX, CMAX, 1, 64)};
        rows = {rows, row(0, 0, 4096, 1, 0, CMAX, CMAX, CMIN, CMIN, 1, 64)};
        rows = {rows, row(0, 0, 4096, 1, 0, 100, -7, -3, 55, 0, -1)};
        rows = {rows, row(1, 0, 0, 1, 0, 0, 0, 5, 0, 0, 6)};
        rows = {rows, row(1, 0, 16777215, 1, 0, CMIN, CMIN, CMAX, CMAX, 1, -1)};
        rows = {rows, row(1, 1, 4096, 0, 0, 1, 2, 3, 4, 1, 2)};
        rows = {rows, row(0, 1, 4096, 0, 0, 1, 2, 3, 4, 0, 1)};
        rows = {rows, row(1, 1, 4096, 62, 1, CMIN, CMAX, CMAX, CMIN, 1, 63)};
        rows = {rows, row(0, 1, 4096, 62, 1, 7, 7, 7, 7, 0, 63)};
        rows = {rows, row(1, 1, 4096, 62, 0, -5, 3, 9, -1, 1, 64)};
        rows = {rows, row(1, 0, 1, 1, 1, 0, 0, 100, 0, 1, 63)};
        rows = {rows, row(1, 1, 4096, 1, 0, 0, 0, 1, -1, 0, 2)};
        rows = {rows, row(0, 1, 4096, 1, 0, -3, 3, 0, 0, 1, 3)};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].set_regs) begin
                idle_input();
                drain();
                set_regs(rows[i].mode, rows[i].max_len, rows[i].count, rows[i].ring);
            end
            send(rows[i].seg, rows[i].n_points, 1'b0);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            idle_input();
            drain();
            case (p)
                0: set_regs(1'b1, 24'hFFFFFF, 62, 1'b0);
                1: set_regs(1'b0, 1, 0, 1'b1);
                2: set_regs(1'b0, 24'hFFFFFF, 33, 1'b0);
                default: begin
                    ml = $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23);
                    set_regs($urandom_range(0, 1), ml, $urandom_range(0, 63),
                             $urandom_range(0, 1));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // fill the block against a stalled receiver
                if (p == 3 && n == 5) hold_req = 1'b1;
                // let every point out before carrying on
                if (p == 5 && n == PHASE_ITEMS / 2) begin
                    idle_input();
                    while (expected_pts.size() != 0) @(posedge i_clk);
                end
                send(random_seg(), -1, p == 3 && n < 20);
            end
        end

        idle_input();
        drain();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

@@ segment_densify_by_length_or_count.f @@
+incdir+hw/rtl
hw/rtl/sdl_pkg.sv
hw/rtl/sdl_ctrl.sv
hw/rtl/sdl_datapath.sv
hw/rtl/segment_densify_by_length_or_count.sv
hw/rtl/sdl_checker.sv
bench/tb.sv
